// File: hdl/wtsp_pkg.sv
// Shared widths, types and register codes for the world-to-screen projection pipeline.
`timescale 1ns / 1ps
package wtsp_pkg;

    localparam int PT_W    = 32;             // Q24.8 point and origin coordinates
    localparam int D_W     = PT_W + 1;       // origin difference
    localparam int AX_W    = 16;             // Q1.14 axis component
    localparam int PR_W    = D_W + AX_W;     // one dot-product term
    localparam int CM_W    = PR_W + 1;       // camera component, sum of three terms
    localparam int MAG_W   = CM_W - 1;       // magnitude of a camera component
    localparam int CTR_W   = 12;             // screen center in pixels
    localparam int SCR_W   = 13;             // screen size register
    localparam int TAN_W   = 16;             // Q4.12 tangent
    localparam int NUM_W   = MAG_W + CTR_W + 12;  // |comp| * center * 4096
    localparam int DEN_W   = MAG_W + TAN_W;  // depth * tangent
    localparam int QBITS   = 18;             // quotient saturation point 2^QBITS
    localparam int CMP_W   = DEN_W + QBITS;  // compare width for shifted divisor
    localparam int RES_W   = 16;             // screen coordinate
    localparam int BASE_W  = QBITS + 3;      // center +/- quotient, signed

    // depth >= 0.01 in Q.22 is depth >= ceil(2^22 / 100)
    localparam logic signed [CM_W-1:0] VIS_MIN = CM_W'(41944);

    localparam int CFG_DW  = 64;
    localparam int CFG_AW  = 6;

    typedef enum logic [2:0] {
        REG_RIGHT   = 3'd0,
        REG_UP      = 3'd1,
        REG_FORWARD = 3'd2,
        REG_ORG_XY  = 3'd3,
        REG_ORG_Z   = 3'd4,
        REG_TAN     = 3'd5,
        REG_WIDTH   = 3'd6,
        REG_HEIGHT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CM_W-1:0] cr;
        logic signed [CM_W-1:0] cu;
        logic signed [CM_W-1:0] cf;
    } cam_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QBITS:0]   q;
        logic             sat;
        logic             neg;
        logic [CTR_W-1:0] center;
    } lane_t;

    typedef struct packed {
        logic  vis;
        lane_t x;
        lane_t y;
    } div_item_t;

endpackage

// File: hdl/world_to_screen_projection.sv
// Top level: configuration registers and the full projection pipeline.
//
//  channel   direction  handshake              payload
//  point     in         in_valid / in_ready    point_x, point_y, point_z
//  screen    out        out_valid / out_ready  visible, screen_x, screen_y
//  config    in         APB psel/penable       paddr, pwdata, prdata
//
// Pipeline: 3 rotate stages, 1 scale stage, 19 divide stages
// (one quotient bit per stage, the first checks saturation), 1 output stage.
// One item per cycle sustained while out_ready is high. Each stage holds its item when the next is
// full, so a stall backs up stage by stage and bubbles are squeezed out.
// Reset clears all valid bits and loads the default camera and viewport.
`timescale 1ns / 1ps
module world_to_screen_projection
    import wtsp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [PT_W-1:0]  point_x,
    input  logic signed [PT_W-1:0]  point_y,
    input  logic signed [PT_W-1:0]  point_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    visible,
    output logic signed [RES_W-1:0] screen_x,
    output logic signed [RES_W-1:0] screen_y,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_AW-1:0]       paddr,
    input  logic [CFG_DW-1:0]       pwdata,
    output logic [CFG_DW-1:0]       prdata,
    output logic                    pready
);

    logic [3*AX_W-1:0]     right_reg, up_reg, fwd_reg;
    logic [63:0]           org_xy_reg;
    logic signed [PT_W-1:0] org_z_reg;
    logic [2*TAN_W-1:0]    tan_reg;
    logic [SCR_W-1:0]      width_reg, height_reg;
    reg_idx_t              idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg  <= 48'h0000_4000_0000;
            up_reg     <= 48'h4000_0000_0000;
            fwd_reg    <= 48'h0000_0000_4000;
            org_xy_reg <= '0;
            org_z_reg  <= '0;
            tan_reg    <= 32'h1000_1000;
            width_reg  <= SCR_W'(640);
            height_reg <= SCR_W'(480);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RIGHT:   right_reg  <= pwdata[3*AX_W-1:0];
                REG_UP:      up_reg     <= pwdata[3*AX_W-1:0];
                REG_FORWARD: fwd_reg    <= pwdata[3*AX_W-1:0];
                REG_ORG_XY:  org_xy_reg <= pwdata;
                REG_ORG_Z:   org_z_reg  <= pwdata[PT_W-1:0];
                REG_TAN:     tan_reg    <= pwdata[2*TAN_W-1:0];
                REG_WIDTH:   width_reg  <= pwdata[SCR_W-1:0];
                REG_HEIGHT:  height_reg <= pwdata[SCR_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RIGHT:   prdata = CFG_DW'(right_reg);
            REG_UP:      prdata = CFG_DW'(up_reg);
            REG_FORWARD: prdata = CFG_DW'(fwd_reg);
            REG_ORG_XY:  prdata = org_xy_reg;
            REG_ORG_Z:   prdata = CFG_DW'(unsigned'(org_z_reg));
            REG_TAN:     prdata = CFG_DW'(tan_reg);
            REG_WIDTH:   prdata = CFG_DW'(width_reg);
            REG_HEIGHT:  prdata = CFG_DW'(height_reg);
            default:     prdata = '0;
        endcase
    end

    logic      rot_valid, rot_ready;
    cam_t      rot_cam;
    logic      stg_valid [QBITS+2];
    logic      stg_ready [QBITS+2];
    div_item_t stg_item  [QBITS+2];

    wtsp_rotate u_rotate (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .px           (point_x),
        .py           (point_y),
        .pz           (point_z),
        .origin_xy    (org_xy_reg),
        .origin_z     (org_z_reg),
        .right_axis   (right_reg),
        .up_axis      (up_reg),
        .forward_axis (fwd_reg),
        .out_valid    (rot_valid),
        .out_ready    (rot_ready),
        .out_cam      (rot_cam)
    );

    wtsp_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (rot_valid),
        .in_ready      (rot_ready),
        .in_cam        (rot_cam),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .tan_half_fov  (tan_reg),
        .out_valid     (stg_valid[0]),
        .out_ready     (stg_ready[0]),
        .out_item      (stg_item[0])
    );

    for (genvar k = 0; k <= QBITS; k++)
    begin : g_div
        wtsp_div_step #(
            .BIT (QBITS - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    wtsp_fixup u_fixup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[QBITS+1]),
        .in_ready  (stg_ready[QBITS+1]),
        .in_item   (stg_item[QBITS+1]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vis       (visible),
        .sx        (screen_x),
        .sy        (screen_y)
    );

endmodule

// File: hdl/wtsp_rotate.sv
// Origin subtract, axis products and dot-product sums: three register stages.
`timescale 1ns / 1ps
module wtsp_rotate
    import wtsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [PT_W-1:0] px,
    input  logic signed [PT_W-1:0] py,
    input  logic signed [PT_W-1:0] pz,
    input  logic [63:0]            origin_xy,
    input  logic signed [PT_W-1:0] origin_z,
    input  logic [3*AX_W-1:0]      right_axis,
    input  logic [3*AX_W-1:0]      up_axis,
    input  logic [3*AX_W-1:0]      forward_axis,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cam_t                   out_cam
);

    logic                   a_valid_reg, b_valid_reg, c_valid_reg;
    logic                   a_ready, b_ready, c_ready;
    logic signed [D_W-1:0]  d_reg [3];
    logic signed [D_W-1:0]  d_next [3];
    logic signed [PR_W-1:0] p_reg [9];
    logic signed [PR_W-1:0] p_next [9];
    cam_t                   cam_reg, cam_next;
    logic signed [AX_W-1:0] ax [9];

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        d_next[0] = D_W'(px) - D_W'($signed(origin_xy[31:0]));
        d_next[1] = D_W'(py) - D_W'($signed(origin_xy[63:32]));
        d_next[2] = D_W'(pz) - D_W'(origin_z);
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            ax[a]     = $signed(right_axis[a*AX_W +: AX_W]);
            ax[3 + a] = $signed(up_axis[a*AX_W +: AX_W]);
            ax[6 + a] = $signed(forward_axis[a*AX_W +: AX_W]);
        end
        for (int k = 0; k < 9; k++)
        begin
            p_next[k] = PR_W'(d_reg[k % 3]) * PR_W'(ax[k]);
        end
    end

    always_comb
    begin
        cam_next.cr = CM_W'(p_reg[0]) + CM_W'(p_reg[1]) + CM_W'(p_reg[2]);
        cam_next.cu = CM_W'(p_reg[3]) + CM_W'(p_reg[4]) + CM_W'(p_reg[5]);
        cam_next.cf = CM_W'(p_reg[6]) + CM_W'(p_reg[7]) + CM_W'(p_reg[8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
            d_reg <= d_next;
        if (b_ready && a_valid_reg)
            p_reg <= p_next;
        if (c_ready && b_valid_reg)
            cam_reg <= cam_next;
    end

    assign out_valid = c_valid_reg;
    assign out_cam   = cam_reg;

endmodule

// File: hdl/wtsp_scale.sv
// Depth test and numerator/denominator products for both screen axes.
`timescale 1ns / 1ps
module wtsp_scale
    import wtsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cam_t               in_cam,
    input  logic [SCR_W-1:0]   screen_width,
    input  logic [SCR_W-1:0]   screen_height,
    input  logic [2*TAN_W-1:0] tan_half_fov,
    output logic               out_valid,
    input  logic               out_ready,
    output div_item_t          out_item
);

    logic      valid_reg;
    div_item_t item_reg, item_next;

    function automatic lane_t make_lane(logic signed [CM_W-1:0] comp,
                                        logic signed [CM_W-1:0] depth,
                                        logic [CTR_W-1:0] center,
                                        logic [TAN_W-1:0] tan_v);
        lane_t                   l;
        logic [MAG_W-1:0]        mag;
        logic [MAG_W+CTR_W-1:0]  prod;
        begin
            mag      = comp[CM_W-1] ? MAG_W'(-comp) : MAG_W'(comp);
            prod     = (MAG_W+CTR_W)'(mag) * (MAG_W+CTR_W)'(center);
            l.rem    = {prod, 12'b0};
            l.den    = DEN_W'(depth[MAG_W-1:0]) * DEN_W'(tan_v);
            l.q      = '0;
            l.sat    = 1'b0;
            l.neg    = comp[CM_W-1];
            l.center = center;
            return l;
        end
    endfunction

    always_comb
    begin
        item_next.vis = (in_cam.cf >= VIS_MIN);
        item_next.x   = make_lane(in_cam.cr, in_cam.cf, screen_width[SCR_W-1:1],
                                  tan_half_fov[TAN_W-1:0]);
        item_next.y   = make_lane(in_cam.cu, in_cam.cf, screen_height[SCR_W-1:1],
                                  tan_half_fov[2*TAN_W-1:TAN_W]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hdl/wtsp_div_step.sv
// One restoring-division stage for both lanes; the top stage does the saturation check.
`timescale 1ns / 1ps
module wtsp_div_step
    import wtsp_pkg::*;
#(
    parameter int BIT = QBITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    logic      valid_reg;
    div_item_t item_reg, item_next;

    function automatic lane_t step(lane_t l);
        lane_t            r;
        logic [CMP_W-1:0] rem_w;
        logic [CMP_W-1:0] dsh;
        begin
            r     = l;
            rem_w = CMP_W'(l.rem);
            dsh   = CMP_W'(l.den) << BIT;
            if (BIT == QBITS)
            begin
                // quotient reaches 2^QBITS, or divide by zero: clamp
                r.sat      = (l.rem != '0) && ((l.den == '0) || (rem_w >= dsh));
                r.q[QBITS] = r.sat;
            end
            // zero divisor with zero numerator keeps a zero quotient
            else if (!l.sat && (l.den != '0) && (rem_w >= dsh))
            begin
                r.rem    = NUM_W'(rem_w - dsh);
                r.q[BIT] = 1'b1;
            end
            return r;
        end
    endfunction

    always_comb
    begin
        item_next.vis = in_item.vis;
        item_next.x   = step(in_item.x);
        item_next.y   = step(in_item.y);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hdl/wtsp_fixup.sv
// Truncation toward zero, 16-bit saturation and visibility masking; output register.
`timescale 1ns / 1ps
module wtsp_fixup
    import wtsp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  div_item_t               in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    vis,
    output logic signed [RES_W-1:0] sx,
    output logic signed [RES_W-1:0] sy
);

    logic                    valid_reg;
    logic                    vis_reg;
    logic signed [RES_W-1:0] sx_reg, sy_reg;

    function automatic logic signed [RES_W-1:0] finish(lane_t l, logic v);
        logic signed [BASE_W-1:0] base;
        logic signed [BASE_W-1:0] res;
        logic                     frac;
        begin
            frac = !l.sat && (l.rem != '0);
            if (!l.neg)
            begin
                base = BASE_W'(l.center) - BASE_W'(l.q);
                res  = (frac && base >= 1) ? base - BASE_W'(1) : base;
            end
            else
            begin
                base = BASE_W'(l.center) + BASE_W'(l.q);
                res  = (frac && base < 0) ? base + BASE_W'(1) : base;
            end
            if (!v)
                return '0;
            else if (res > 32767)
                return RES_W'(32767);
            else if (res < -32768)
                return RES_W'(-32768);
            else
                return RES_W'(res);
        end
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vis_reg <= in_item.vis;
            sx_reg  <= finish(in_item.x, in_item.vis);
            sy_reg  <= finish(in_item.y, in_item.vis);
        end
    end

    assign out_valid = valid_reg;
    assign vis       = vis_reg;
    assign sx        = sx_reg;
    assign sy        = sy_reg;

endmodule

// File: verif/wtsp_checker.sv
// Checker for the projection block: mirrors the registers, predicts each screen item and compares.
`timescale 1ns / 1ps
module wtsp_checker
    import wtsp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic signed [PT_W-1:0]  point_x,
    input  logic signed [PT_W-1:0]  point_y,
    input  logic signed [PT_W-1:0]  point_z,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic                    visible,
    input  logic signed [RES_W-1:0] screen_x,
    input  logic signed [RES_W-1:0] screen_y,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_AW-1:0]       paddr,
    input  logic [CFG_DW-1:0]       pwdata,
    input  logic                    pready,
    output int                      errors,
    output int                      pending,
    output int                      n_results,
    output int                      n_visible
);

    typedef struct {
        logic                    vis;
        logic signed [RES_W-1:0] sx;
        logic signed [RES_W-1:0] sy;
    } pixel_t;

    pixel_t      pixel_q[$];

    logic [47:0] right_ax, up_ax, fwd_ax;
    logic [63:0] org_xy;
    logic [31:0] org_z, tan_fov;
    logic [12:0] scr_w, scr_h;

    function automatic longint axis_dot(longint dx, longint dy, longint dz, logic [47:0] ax);
        return dx * longint'($signed(ax[15:0])) + dy * longint'($signed(ax[31:16]))
             + dz * longint'($signed(ax[47:32]));
    endfunction

    // center - center*4096*comp/(tan*depth), truncated toward zero, saturated
    function automatic logic signed [RES_W-1:0] scale_axis(longint comp, longint depth,
                                                          logic [11:0] center, logic [15:0] tan);
        logic [127:0] num, den, quo;
        longint       base, res;
        bit           frac;
        num  = 128'(comp < 0 ? -comp : comp) * 128'(center);
        num  = num << 12;
        den  = 128'(depth) * 128'(tan);
        quo  = 0;
        frac = 0;
        if (num != 0) begin
            if (den == 0 || num >= (den << QBITS))
                quo = 128'(1) << QBITS;
            else
            begin
                quo  = num / den;
                frac = (num % den) != 0;
            end
        end
        if (comp >= 0)
        begin
            base = longint'(center) - longint'(quo[31:0]);
            res  = (frac && base >= 1) ? base - 1 : base;
        end
        else
        begin
            base = longint'(center) + longint'(quo[31:0]);
            res  = (frac && base < 0) ? base + 1 : base;
        end
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[RES_W-1:0];
    endfunction

    function automatic pixel_t project_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        pixel_t p;
        longint dx, dy, dz, cr, cu, cf;
        dx = longint'($signed(px)) - longint'($signed(org_xy[31:0]));
        dy = longint'($signed(py)) - longint'($signed(org_xy[63:32]));
        dz = longint'($signed(pz)) - longint'($signed(org_z));
        cr = axis_dot(dx, dy, dz, right_ax);
        cu = axis_dot(dx, dy, dz, up_ax);
        cf = axis_dot(dx, dy, dz, fwd_ax);
        p.vis = 0;
        p.sx  = 0;
        p.sy  = 0;
        if (cf * 100 >= 64'sd4194304)
        begin
            p.vis = 1;
            p.sx  = scale_axis(cr, cf, 12'(scr_w >> 1), tan_fov[15:0]);
            p.sy  = scale_axis(cu, cf, 12'(scr_h >> 1), tan_fov[31:16]);
        end
        return p;
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        errors++;
    endtask

    initial
    begin
        errors    = 0;
        pending   = 0;
        n_results = 0;
        n_visible = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            right_ax = 48'd1073741824;
            up_ax    = 48'd70368744177664;
            fwd_ax   = 48'd16384;
            org_xy   = '0;
            org_z    = '0;
            tan_fov  = 32'd268439552;
            scr_w    = 13'd640;
            scr_h    = 13'd480;
            pixel_q.delete();
            pending  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pixel_q.size() == 0)
                begin
                    $display("unexpected screen item at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (want.vis) n_visible++;
                    if (visible !== want.vis) report("visible", want.vis, visible);
                    if (screen_x !== want.sx) report("screen_x", want.sx, screen_x);
                    if (screen_y !== want.sy) report("screen_y", want.sy, screen_y);
                end
            end
            // a point accepted at this edge sees the registers as they were before it
            if (in_valid && in_ready)
                pixel_q.push_back(project_point(point_x, point_y, point_z));
            pending = pixel_q.size();
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[5:3]))
                    REG_RIGHT:   right_ax = pwdata[47:0];
                    REG_UP:      up_ax    = pwdata[47:0];
                    REG_FORWARD: fwd_ax   = pwdata[47:0];
                    REG_ORG_XY:  org_xy   = pwdata;
                    REG_ORG_Z:   org_z    = pwdata[31:0];
                    REG_TAN:     tan_fov  = pwdata[31:0];
                    REG_WIDTH:   scr_w    = pwdata[12:0];
                    REG_HEIGHT:  scr_h    = pwdata[12:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: verif/tb.sv
// Testbench top: drives points and camera setups into the projection block and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import wtsp_pkg::*;

    localparam int N_RANDOM  = 1880;
    localparam int MAX_CYCLE = 400000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [PT_W-1:0]  point_x, point_y, point_z;
    logic                    out_valid;
    logic                    out_ready;
    logic                    visible;
    logic signed [RES_W-1:0] screen_x, screen_y;
    logic                    psel, penable, pwrite, pready;
    logic [CFG_AW-1:0]       paddr;
    logic [CFG_DW-1:0]       pwdata, prdata;

    int errors, pending, n_results, n_visible;
    int cycles;
    int n_setups;
    int stall_mode, stall_left;

    world_to_screen_projection u_top (.*);

    wtsp_checker u_chk (
        .clk, .rst_n, .in_valid, .in_ready, .point_x, .point_y, .point_z,
        .out_valid, .out_ready, .visible, .screen_x, .screen_y,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .errors, .pending, .n_results, .n_visible
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stalls in stretches: always ready, coin flip, mostly stalled, fully stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(5, 60);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= 1'b0;
            endcase
        end
    end

    // caller is at a rising edge; returns at the edge that accepts the item, valid left high
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_valid <= 1'b1;
        point_x  <= x;
        point_y  <= y;
        point_z  <= z;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
        end
    endtask

    // one edge first so the checker has logged the last accepted item
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [47:0] rand_axis(int kind);
        case (kind)
            0: return 48'({$urandom, $urandom});
            1: return 48'h8000_8000_8000;
            2: return 48'h7FFF_7FFF_7FFF;
            default: return {16'($urandom_range(0, 8192) - 4096), 16'($urandom_range(0, 8192) - 4096),
                             16'($urandom_range(0, 32768) - 16384)};
        endcase
    endfunction

    // kinds: 0 threshold/zero tangent, 1 random, 2 negative extremes, 3 positive extremes
    task automatic setup_camera(int kind);
        drain();
        n_setups++;
        case (kind)
            0:
            begin
                reg_write(REG_RIGHT, 64'd1073741824);
                reg_write(REG_UP, 64'd70368744177664);
                reg_write(REG_FORWARD, 64'd1);
                reg_write(REG_ORG_XY, 64'd0);
                reg_write(REG_ORG_Z, 64'd0);
                reg_write(REG_TAN, 64'd0);
                reg_write(REG_WIDTH, 64'd1);
                reg_write(REG_HEIGHT, 64'd4096);
            end
            1:
            begin
                reg_write(REG_RIGHT, rand_axis($urandom_range(0, 1) ? 0 : 3));
                reg_write(REG_UP, rand_axis($urandom_range(0, 1) ? 0 : 3));
                reg_write(REG_FORWARD, rand_axis(3));
                reg_write(REG_ORG_XY, {32'($urandom_range(0, 4096) - 2048),
                                       32'($urandom_range(0, 4096) - 2048)});
                reg_write(REG_ORG_Z, 32'($urandom_range(0, 4096) - 2048));
                reg_write(REG_TAN, {16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))});
                reg_write(REG_WIDTH, $urandom_range(1, 4096));
                reg_write(REG_HEIGHT, $urandom_range(1, 4096));
            end
            2:
            begin
                reg_write(REG_RIGHT, rand_axis(1));
                reg_write(REG_UP, rand_axis(0));
                reg_write(REG_FORWARD, rand_axis(1));
                reg_write(REG_ORG_XY, 64'h7FFF_FFFF_8000_0000);
                reg_write(REG_ORG_Z, 64'h8000_0000);
                reg_write(REG_TAN, 64'hFFFF_FFFF);
                reg_write(REG_WIDTH, 64'd4096);
                reg_write(REG_HEIGHT, 64'd1);
            end
            default:
            begin
                reg_write(REG_RIGHT, rand_axis(2));
                reg_write(REG_UP, rand_axis(2));
                reg_write(REG_FORWARD, rand_axis(2));
                reg_write(REG_ORG_XY, {$urandom, $urandom});
                reg_write(REG_ORG_Z, $urandom);
                reg_write(REG_TAN, {16'($urandom_range(1, 65535)), 16'h0001});
                reg_write(REG_WIDTH, 64'd4096);
                reg_write(REG_HEIGHT, 64'd4096);
            end
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        int pick;
        logic [31:0] picks [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        pick = $urandom_range(0, 99);
        if (pick < 60) return 32'($urandom_range(0, 131072) - 65536);
        if (pick < 85) return $urandom;
        return picks[$urandom_range(0, 3)];
    endfunction

    initial
    begin
        int i, gap, burst;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        point_x  = '0;
        point_y  = '0;
        point_z  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cycles   = 0;
        n_setups = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset camera: behind, origin, extremes, plain view cases
        send_point(0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_point(2560, 0, 0);
        send_point(2560, 1280, -768);
        send_point(-256, 512, 512);
        send_point(3, 0, 0);
        send_point(2, 0, 0);

        // depth threshold at raw forward 1, zero tangent saturates both ways
        setup_camera(0);
        send_point(41943, 0, 0);
        send_point(41944, 0, 0);
        send_point(41944, 100, -100);
        send_point(41944, -100, 100);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(-41944, 5, 5);

        setup_camera(2);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_point(-1000, -1000, -1000);
        setup_camera(3);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

        i = 0;
        while (i < N_RANDOM)
        begin
            if (i % 300 == 0) setup_camera((i / 300) % 4 == 0 ? 1 : $urandom_range(0, 3));
            burst = $urandom_range(1, 40);
            while (burst > 0 && i < N_RANDOM)
            begin
                send_point(rand_coord(), rand_coord(), rand_coord());
                burst--;
                i++;
                if (i % 300 == 0 || i == N_RANDOM / 2)
                    break;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (i == N_RANDOM / 2)
                drain();
            else if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        drain();
        $display("covered %0d screen items (%0d visible) over %0d camera setups", n_results,
                 n_visible, n_setups);
        $display("setups included zero tangent, depth threshold and extreme axes and origins");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
